// ===== rtl/core/rfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Rangefinder response deframer package
// Shared widths, response codes, result kinds and the result record.
// ----------------------------------------------------------------------------
package rfd_pkg;

	localparam int BYTE_W     = 8;
	localparam int KIND_W     = 3;
	localparam int DIST_W     = 16;
	localparam int LCOUNT_W   = 23;
	localparam int PROD_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int BODY_LEN   = 6;
	localparam int BODY_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE = 1'd1;

	localparam logic [BYTE_W-1:0] RSP_SELF_CHECK = 8'h01;
	localparam logic [BYTE_W-1:0] RSP_RANGE_A    = 8'h0B;
	localparam logic [BYTE_W-1:0] RSP_RANGE_B    = 8'h0C;
	localparam logic [BYTE_W-1:0] RSP_RANGE_C    = 8'h02;
	localparam logic [BYTE_W-1:0] RSP_RANGE_D    = 8'h04;
	localparam logic [BYTE_W-1:0] RSP_PULSES     = 8'h0A;
	localparam logic [BYTE_W-1:0] RSP_PRODUCT    = 8'h10;
	localparam logic [BYTE_W-1:0] RSP_TEMP       = 8'h06;
	localparam logic [BYTE_W-1:0] FAULT_CODE     = 8'h01;

	localparam logic [KIND_W-1:0] KIND_SELF_CHECK = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RANGING    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PULSES     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PRODUCT    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TEMP       = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CSUM_ERR   = 3'd5;

	localparam logic [LCOUNT_W-1:0] LASER_SCALE = 23'd100;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [BYTE_W-1:0]   status_byte;
		logic                fault;
		logic                no_echo;
		logic                laser_not_out;
		logic                over_temperature;
		logic [DIST_W-1:0]   distance;
		logic                range_valid;
		logic [BYTE_W-1:0]   pulse_count;
		logic [LCOUNT_W-1:0] laser_count;
		logic signed [BYTE_W-1:0] temperature;
		logic [PROD_W-1:0]   product_version;
	} result_t;

endpackage

// ===== rtl/core/rfd_if.sv =====
// ----------------------------------------------------------------------------
// Rangefinder response deframer channels
// Received byte, configuration write and decoded result channels.
// ----------------------------------------------------------------------------
interface rfd_byte_if;
	logic                          valid;
	logic                          ready;
	logic [rfd_pkg::BYTE_W-1:0]    rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rfd_pkg::CFG_IDX_W-1:0] index;
	logic [rfd_pkg::BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface rfd_result_if;
	logic                             valid;
	logic                             ready;
	logic [rfd_pkg::KIND_W-1:0]       kind;
	logic [rfd_pkg::BYTE_W-1:0]       status_byte;
	logic                             fault;
	logic                             no_echo;
	logic                             laser_not_out;
	logic                             over_temperature;
	logic [rfd_pkg::DIST_W-1:0]       distance;
	logic                             range_valid;
	logic [rfd_pkg::BYTE_W-1:0]       pulse_count;
	logic [rfd_pkg::LCOUNT_W-1:0]     laser_count;
	logic signed [rfd_pkg::BYTE_W-1:0] temperature;
	logic [rfd_pkg::PROD_W-1:0]       product_version;

	modport source (output valid, output kind, output status_byte, output fault,
		output no_echo, output laser_not_out, output over_temperature,
		output distance, output range_valid, output pulse_count,
		output laser_count, output temperature, output product_version,
		input ready);
	modport sink (input valid, input kind, input status_byte, input fault,
		input no_echo, input laser_not_out, input over_temperature,
		input distance, input range_valid, input pulse_count,
		input laser_count, input temperature, input product_version,
		output ready);
endinterface

// ===== rtl/core/rangefinder_response_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Rangefinder response deframer
// Finds nine-byte response frames in a byte stream and decodes them.
// ----------------------------------------------------------------------------
// The block takes one received word per clock cycle unless a result is due
// while the output register is full, and emits at most one result word per
// frame: the checksum word passes the input register, then the result is
// registered in the output register. Throughput is one word per cycle, set by
// the frame state registers that each word updates, under the same condition.
// A result waiting in the output register does not stop intake until the next
// result is due. The user must write the header and device codes through the
// configuration channel while the block is idle; the block does not check it.
module rangefinder_response_deframer_top (
	input  logic              clk,
	input  logic              arst_n,
	rfd_cfg_if.sink           cfg,
	rfd_byte_if.sink          rx,
	rfd_result_if.source      res
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_DEVICE  = 2'd1;
	localparam logic [1:0] PH_COLLECT = 2'd2;
	localparam logic [rfd_pkg::BODY_IDX_W-1:0] CSUM_IDX =
		rfd_pkg::BODY_IDX_W'(rfd_pkg::BODY_LEN);

	logic [rfd_pkg::BYTE_W-1:0]     header_q;
	logic [rfd_pkg::BYTE_W-1:0]     device_q;
	logic                           valid_s1;
	logic [rfd_pkg::BYTE_W-1:0]     byte_s1;
	logic [1:0]                     phase_q;
	logic [rfd_pkg::BODY_IDX_W-1:0] idx_q;
	logic [rfd_pkg::BYTE_W-1:0]     sum_q;
	logic [rfd_pkg::BYTE_W-1:0]     body_q [rfd_pkg::BODY_LEN];
	logic                           out_valid_q;
	rfd_pkg::result_t               res_q;

	logic                           out_free;
	logic                           at_csum;
	logic                           emit;
	logic                           adv_s1;
	logic                           known;
	rfd_pkg::result_t               dec;
	logic [rfd_pkg::BYTE_W-1:0]     code;
	logic [rfd_pkg::BYTE_W-1:0]     st;
	logic [rfd_pkg::BYTE_W-2:0]     mag;
	logic [rfd_pkg::DIST_W-1:0]     range_dist;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			device_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rfd_pkg::CFG_HEADER: header_q <= cfg.data;
				rfd_pkg::CFG_DEVICE: device_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || res.ready;
	assign at_csum  = (phase_q == PH_COLLECT) && (idx_q == CSUM_IDX);
	assign emit     = at_csum && ((byte_s1 != sum_q) || known);
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign rx.ready = !valid_s1 || adv_s1;

	always_comb begin
		code = body_q[0];
		mag  = body_q[2][rfd_pkg::BYTE_W-2:0];
		range_dist = {body_q[3], body_q[4]};
		st   = '0;
		dec  = '0;
		known = 1'b1;
		case (code) inside
			rfd_pkg::RSP_SELF_CHECK: begin
				dec.kind = rfd_pkg::KIND_SELF_CHECK;
				st = body_q[2];
				dec.fault = (body_q[1] == rfd_pkg::FAULT_CODE);
			end
			rfd_pkg::RSP_RANGE_A, rfd_pkg::RSP_RANGE_B,
			rfd_pkg::RSP_RANGE_C, rfd_pkg::RSP_RANGE_D: begin
				dec.kind = rfd_pkg::KIND_RANGING;
				st = body_q[1];
				dec.fault = (body_q[1] == rfd_pkg::FAULT_CODE);
				dec.distance = range_dist;
				dec.range_valid = (range_dist != '0) && !st[3] &&
					(body_q[1] != rfd_pkg::FAULT_CODE);
				dec.pulse_count = body_q[5];
			end
			rfd_pkg::RSP_PULSES: begin
				dec.kind = rfd_pkg::KIND_PULSES;
				dec.laser_count = rfd_pkg::LCOUNT_W'({body_q[4], body_q[3]}) *
					rfd_pkg::LASER_SCALE;
			end
			rfd_pkg::RSP_PRODUCT: begin
				dec.kind = rfd_pkg::KIND_PRODUCT;
				dec.product_version = {body_q[1], body_q[2]};
			end
			rfd_pkg::RSP_TEMP: begin
				dec.kind = rfd_pkg::KIND_TEMP;
				dec.temperature = body_q[2][rfd_pkg::BYTE_W-1] ?
					-$signed({1'b0, mag}) : $signed({1'b0, mag});
			end
			default: known = 1'b0;
		endcase
		dec.status_byte      = st;
		dec.no_echo          = st[3];
		dec.laser_not_out    = st[4];
		dec.over_temperature = st[5];
		if (byte_s1 != sum_q) begin
			dec = '0;
			dec.kind = rfd_pkg::KIND_CSUM_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q   <= '0;
			sum_q   <= '0;
		end else if (adv_s1) begin
			if (phase_q == PH_COLLECT) begin
				if (at_csum) begin
					phase_q <= PH_HUNT;
					idx_q   <= '0;
					sum_q   <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
					sum_q <= sum_q + byte_s1;
				end
			end else if (phase_q == PH_DEVICE && byte_s1 == device_q) begin
				phase_q <= PH_COLLECT;
				idx_q   <= '0;
				sum_q   <= '0;
			end else begin
				phase_q <= (byte_s1 == header_q) ? PH_DEVICE : PH_HUNT;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < rfd_pkg::BODY_LEN; i++) begin
			if (adv_s1 && phase_q == PH_COLLECT &&
				idx_q == rfd_pkg::BODY_IDX_W'(i)) begin
				body_q[i] <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			res_q <= dec;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.kind             = res_q.kind;
	assign res.status_byte      = res_q.status_byte;
	assign res.fault            = res_q.fault;
	assign res.no_echo          = res_q.no_echo;
	assign res.laser_not_out    = res_q.laser_not_out;
	assign res.over_temperature = res_q.over_temperature;
	assign res.distance         = res_q.distance;
	assign res.range_valid      = res_q.range_valid;
	assign res.pulse_count      = res_q.pulse_count;
	assign res.laser_count      = res_q.laser_count;
	assign res.temperature      = res_q.temperature;
	assign res.product_version  = res_q.product_version;

endmodule

// ===== tb/rangefinder_response_deframer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rangefinder response deframer testbench
// Feeds received words through the byte channel and checks every decoded
// result against a cycle-free model of the deframer held in the testbench.
// Directed frames cover the reset codes, header recovery and checksum errors.
// Random phases then run frames, noise and broken frames under several code
// settings, with bursts of idle cycles and output stalls.
// ----------------------------------------------------------------------------
module rangefinder_response_deframer_top_test;

	typedef enum logic [1:0] {
		HUNT_HEADER,
		WAIT_DEVICE,
		COLLECT_BODY
	} frame_phase_t;

	typedef logic [rfd_pkg::BODY_LEN-1:0][rfd_pkg::BYTE_W-1:0] body_t;

	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;

	rfd_cfg_if    cfg ();
	rfd_byte_if   rx ();
	rfd_result_if res ();

	rangefinder_response_deframer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.res    (res)
	);

	logic [rfd_pkg::BYTE_W-1:0]     header_code;
	logic [rfd_pkg::BYTE_W-1:0]     device_code;
	frame_phase_t                   frame_phase;
	logic [rfd_pkg::BODY_IDX_W-1:0] body_pos;
	body_t                          body_words;
	logic [rfd_pkg::BYTE_W-1:0]     body_sum;

	rfd_pkg::result_t due_reports [$];
	int      mismatches;
	int      words_sent;
	bit      gaps_on;
	bit      stalls_on;
	int      stall_left;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic rfd_pkg::result_t decode_body(input body_t b);
		rfd_pkg::result_t r;
		r = '0;
		if (b[0] == rfd_pkg::RSP_SELF_CHECK) begin
			r.kind = rfd_pkg::KIND_SELF_CHECK;
			r.status_byte = b[2];
			r.fault = (b[1] == rfd_pkg::FAULT_CODE);
		end else if (b[0] == rfd_pkg::RSP_RANGE_A || b[0] == rfd_pkg::RSP_RANGE_B ||
				b[0] == rfd_pkg::RSP_RANGE_C || b[0] == rfd_pkg::RSP_RANGE_D) begin
			r.kind = rfd_pkg::KIND_RANGING;
			r.status_byte = b[1];
			r.fault = (b[1] == rfd_pkg::FAULT_CODE);
			r.distance = {b[3], b[4]};
			r.pulse_count = b[5];
		end else if (b[0] == rfd_pkg::RSP_PULSES) begin
			r.kind = rfd_pkg::KIND_PULSES;
			r.laser_count = rfd_pkg::LCOUNT_W'({b[4], b[3]}) * rfd_pkg::LASER_SCALE;
		end else if (b[0] == rfd_pkg::RSP_PRODUCT) begin
			r.kind = rfd_pkg::KIND_PRODUCT;
			r.product_version = {b[1], b[2]};
		end else if (b[0] == rfd_pkg::RSP_TEMP) begin
			r.kind = rfd_pkg::KIND_TEMP;
			r.temperature = b[2][7] ? -{1'b0, b[2][6:0]} : {1'b0, b[2][6:0]};
		end
		if (r.kind == rfd_pkg::KIND_SELF_CHECK || r.kind == rfd_pkg::KIND_RANGING) begin
			r.no_echo = r.status_byte[3];
			r.laser_not_out = r.status_byte[4];
			r.over_temperature = r.status_byte[5];
		end
		if (r.kind == rfd_pkg::KIND_RANGING)
			r.range_valid = (r.distance != 0) && !r.no_echo && !r.fault;
		return r;
	endfunction

	function automatic bit known_code(input logic [rfd_pkg::BYTE_W-1:0] code);
		return code == rfd_pkg::RSP_SELF_CHECK || code == rfd_pkg::RSP_RANGE_A ||
			code == rfd_pkg::RSP_RANGE_B || code == rfd_pkg::RSP_RANGE_C ||
			code == rfd_pkg::RSP_RANGE_D || code == rfd_pkg::RSP_PULSES ||
			code == rfd_pkg::RSP_PRODUCT || code == rfd_pkg::RSP_TEMP;
	endfunction

	task automatic track_word(input logic [rfd_pkg::BYTE_W-1:0] w);
		rfd_pkg::result_t r;
		if (frame_phase == COLLECT_BODY) begin
			if (body_pos < rfd_pkg::BODY_LEN) begin
				body_words[body_pos] = w;
				body_sum = body_sum + w;
				body_pos = body_pos + 1'b1;
			end else begin
				if (w == body_sum) begin
					if (known_code(body_words[0]))
						due_reports.insert(due_reports.size(), decode_body(body_words));
				end else begin
					r = '0;
					r.kind = rfd_pkg::KIND_CSUM_ERR;
					due_reports.insert(due_reports.size(), r);
				end
				frame_phase = HUNT_HEADER;
				body_pos = '0;
				body_sum = '0;
			end
		end else if (frame_phase == WAIT_DEVICE && w == device_code) begin
			frame_phase = COLLECT_BODY;
			body_pos = '0;
			body_sum = '0;
		end else begin
			frame_phase = (w == header_code) ? WAIT_DEVICE : HUNT_HEADER;
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		rfd_pkg::result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (due_reports.size() == 0) begin
				$display("%0t: result expected none actual kind %0d", $time, res.kind);
				mismatches++;
			end else begin
				want = due_reports.pop_front();
				check_field("kind", 32'(want.kind), 32'(res.kind));
				check_field("status_byte", 32'(want.status_byte), 32'(res.status_byte));
				check_field("fault", 32'(want.fault), 32'(res.fault));
				check_field("no_echo", 32'(want.no_echo), 32'(res.no_echo));
				check_field("laser_not_out", 32'(want.laser_not_out),
					32'(res.laser_not_out));
				check_field("over_temperature", 32'(want.over_temperature),
					32'(res.over_temperature));
				check_field("distance", 32'(want.distance), 32'(res.distance));
				check_field("range_valid", 32'(want.range_valid), 32'(res.range_valid));
				check_field("pulse_count", 32'(want.pulse_count), 32'(res.pulse_count));
				check_field("laser_count", 32'(want.laser_count), 32'(res.laser_count));
				check_field("temperature", 32'(want.temperature), 32'(res.temperature));
				check_field("product_version", 32'(want.product_version),
					32'(res.product_version));
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res.ready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 16);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	task automatic send_word(input logic [rfd_pkg::BYTE_W-1:0] w);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			rx.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= w;
		do @(posedge clk); while (!rx.ready);
		track_word(w);
		words_sent++;
	endtask

	task automatic send_packet(input body_t b, input bit bad_sum);
		logic [rfd_pkg::BYTE_W-1:0] sum;
		sum = '0;
		for (int i = 0; i < rfd_pkg::BODY_LEN; i++)
			sum = sum + b[i];
		if (bad_sum)
			sum = sum ^ rfd_pkg::BYTE_W'($urandom_range(1, 255));
		send_word(header_code);
		send_word(device_code);
		for (int i = 0; i < rfd_pkg::BODY_LEN; i++)
			send_word(b[i]);
		send_word(sum);
	endtask

	task automatic drain_results();
		rx.valid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rfd_pkg::CFG_IDX_W-1:0] idx,
			input logic [rfd_pkg::BYTE_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == rfd_pkg::CFG_HEADER)
			header_code = val;
		else
			device_code = val;
	endtask

	task automatic set_codes(input logic [rfd_pkg::BYTE_W-1:0] hdr,
			input logic [rfd_pkg::BYTE_W-1:0] dev);
		drain_results();
		write_reg(rfd_pkg::CFG_HEADER, hdr);
		write_reg(rfd_pkg::CFG_DEVICE, dev);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [rfd_pkg::BYTE_W-1:0] rand_word();
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 4))
				0: return 8'h00;
				1: return 8'h01;
				2: return 8'h7F;
				3: return 8'h80;
				default: return 8'hFF;
			endcase
		end
		return rfd_pkg::BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic body_t rand_body();
		body_t b;
		case ($urandom_range(0, 8))
			0: b[0] = rfd_pkg::RSP_SELF_CHECK;
			1: b[0] = rfd_pkg::RSP_RANGE_A;
			2: b[0] = rfd_pkg::RSP_RANGE_B;
			3: b[0] = rfd_pkg::RSP_RANGE_C;
			4: b[0] = rfd_pkg::RSP_RANGE_D;
			5: b[0] = rfd_pkg::RSP_PULSES;
			6: b[0] = rfd_pkg::RSP_PRODUCT;
			7: b[0] = rfd_pkg::RSP_TEMP;
			default: b[0] = $urandom_range(0, 1) ? 8'h05 : rand_word();
		endcase
		for (int i = 1; i < rfd_pkg::BODY_LEN; i++)
			b[i] = rand_word();
		if ($urandom_range(0, 3) == 0)
			b[1] = rfd_pkg::FAULT_CODE;
		if ($urandom_range(0, 7) == 0)
			{b[3], b[4]} = '0;
		return b;
	endfunction

	task automatic test_reset_codes();
		send_packet({8'h33, 8'h22, 8'h11, 8'h80, 8'h00, rfd_pkg::RSP_TEMP}, 1'b0);
	endtask

	task automatic test_header_recovery();
		set_codes(8'hFF, 8'h00);
		send_word(8'hFF);
		send_packet({8'h00, 8'h00, 8'h00, 8'h38, rfd_pkg::FAULT_CODE,
			rfd_pkg::RSP_SELF_CHECK}, 1'b0);
	endtask

	task automatic test_checksum_error();
		send_packet({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, rfd_pkg::RSP_RANGE_A}, 1'b1);
	endtask

	task automatic run_traffic(input int n_words);
		int start;
		int pick;
		start = words_sent;
		while (words_sent - start < n_words) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				send_packet(rand_body(), 1'b0);
			end else if (pick < 82) begin
				send_packet(rand_body(), 1'b1);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) send_word(rand_word());
			end else if (pick < 95) begin
				send_word(header_code);
				send_word(rand_word());
			end else begin
				send_word(header_code);
				send_packet(rand_body(), 1'b0);
			end
		end
	endtask

	task automatic test_random_phases();
		logic [rfd_pkg::BYTE_W-1:0] hdrs [6];
		logic [rfd_pkg::BYTE_W-1:0] devs [6];
		hdrs = '{8'h00, 8'hFF, 8'hA5, 8'h7E, 8'h00, 8'h00};
		devs = '{8'hFF, 8'h00, 8'hA5, 8'h81, 8'h00, 8'h00};
		hdrs[4] = rand_word();
		devs[4] = rand_word();
		hdrs[5] = rfd_pkg::BYTE_W'($urandom_range(0, 255));
		devs[5] = rfd_pkg::BYTE_W'($urandom_range(0, 255));
		for (int p = 0; p < 6; p++) begin
			set_codes(hdrs[p], devs[p]);
			gaps_on = (p == 0 || p == 1 || p == 3 || (p == 4 && $urandom_range(0, 1)));
			stalls_on = (p == 0 || p == 2 || p == 3 || (p == 4 && $urandom_range(0, 1)));
			if (p == 3) begin
				run_traffic(100);
				drain_results();
				run_traffic(115);
			end else begin
				run_traffic(215);
			end
		end
	endtask

	initial begin
		#2_000_000;
		$display("rangefinder_response_deframer_top_test: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		cfg.valid = 1'b0;
		cfg.index = rfd_pkg::CFG_HEADER;
		cfg.data = '0;
		res.ready = 1'b0;
		stall_left = 0;
		mismatches = 0;
		words_sent = 0;
		header_code = '0;
		device_code = '0;
		frame_phase = HUNT_HEADER;
		body_pos = '0;
		body_words = '0;
		body_sum = '0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_codes();
		test_header_recovery();
		test_checksum_error();
		test_random_phases();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_reports.size() == 0)
			$display("rangefinder_response_deframer_top_test: clean");
		else
			$display("rangefinder_response_deframer_top_test: errors");
		$finish;
	end

endmodule
